FILE: rtl/gasp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gasp_pkg
// Types, constants and helper functions shared by the grid path search.
// ---------------------------------------------------------------------------
package gasp_pkg;
    localparam int GRID_W = 8;
    localparam int GRID_H = 8;
    localparam int CELL_COUNT = GRID_W * GRID_H;
    localparam int CW = $clog2(CELL_COUNT);

    localparam logic [1:0] REQ_SET_WALL   = 2'd0;
    localparam logic [1:0] REQ_CLEAR_WALL = 2'd1;
    localparam logic [1:0] REQ_CLEAR_ALL  = 2'd2;
    localparam logic [1:0] REQ_SEARCH     = 2'd3;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_DIAG   = 2'd2;
    localparam logic [1:0] CFG_HEUR   = 2'd3;

    localparam logic [1:0] HEUR_MANHATTAN = 2'd0;
    localparam logic [1:0] HEUR_EUCLID    = 2'd1;
    localparam logic [1:0] HEUR_OCTAGON   = 2'd2;

    localparam logic [9:0] COST_STRAIGHT = 10'd10;
    localparam logic [9:0] COST_DIAGONAL = 10'd14;

    typedef struct packed {
        logic [1:0] req_type;
        logic [2:0] cell_x;
        logic [2:0] cell_y;
        logic [2:0] start_x;
        logic [2:0] start_y;
        logic [2:0] goal_x;
        logic [2:0] goal_y;
    } t_req;

    typedef struct packed {
        logic [2:0] path_x;
        logic [2:0] path_y;
        logic       found;
        logic       last;
    } t_res;

    typedef struct packed {
        logic [2:0] cfg_index;
        logic [3:0] cfg_data;
    } t_cfg;

    // One entry of the per-cell search store.
    typedef struct packed {
        logic [9:0] g;
        logic [7:0] h;
        logic [2:0] par;
        logic [6:0] ord;
    } t_node;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture request
        logic wall_wr;    // single wall edit
        logic wall_clr;   // clear all walls
        logic clr_flags;  // clear open/closed/counter (flip-flops)
        logic seed;       // seed goal cell
        logic scan_init;  // reset scan best
        logic scan_step;  // examine one cell
        logic expand;     // close best, start neighbour index
        logic nb_read;    // fetch the store entry of one neighbour
        logic nb_step;    // process one neighbour
        logic path_init;  // cursor to start
        logic path_step;  // cursor to parent
    } t_cmd;

    typedef struct packed {
        logic bad_coord;
        logic scan_done;
        logic best_none;
        logic best_is_start;
        logic nb_done;
        logic path_at_goal;
        logic path_stop;
        logic [2:0] cur_x;
        logic [2:0] cur_y;
    } t_sts;

    function automatic logic signed [1:0] step_dx(input logic [2:0] d);
        unique case (d)
            3'd0: step_dx = 2'sd0;
            3'd1: step_dx = 2'sd1;
            3'd2: step_dx = 2'sd0;
            3'd3: step_dx = -2'sd1;
            3'd4: step_dx = -2'sd1;
            3'd5: step_dx = 2'sd1;
            3'd6: step_dx = -2'sd1;
            default: step_dx = 2'sd1;
        endcase
    endfunction

    function automatic logic signed [1:0] step_dy(input logic [2:0] d);
        unique case (d)
            3'd0: step_dy = 2'sd1;
            3'd1: step_dy = 2'sd0;
            3'd2: step_dy = -2'sd1;
            3'd3: step_dy = 2'sd0;
            3'd4: step_dy = -2'sd1;
            3'd5: step_dy = 2'sd1;
            3'd6: step_dy = 2'sd1;
            default: step_dy = -2'sd1;
        endcase
    endfunction

    // floor(10*sqrt(n)) for n = dx^2+dy^2, dx,dy in 0..7 (n up to 98).
    function automatic logic [7:0] euclid_lut(input logic [6:0] n);
        logic [7:0] r;
        logic [13:0] t;
        r = 8'd0;
        for (int k = 1; k < 100; k++) begin
            t = 14'(k * k);
            if (t <= 14'(100 * n)) r = 8'(k);
        end
        euclid_lut = r;
    endfunction

    function automatic logic [7:0] estimate(input logic [2:0] ax, input logic [2:0] ay,
                                            input logic [2:0] bx, input logic [2:0] by,
                                            input logic [1:0] mode);
        logic [2:0] dx;
        logic [2:0] dy;
        logic [2:0] lo;
        logic [7:0] man;
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        lo = (dx < dy) ? dx : dy;
        man = 8'd10 * ({5'd0, dx} + {5'd0, dy});
        unique case (mode)
            HEUR_EUCLID:  estimate = euclid_lut(7'({4'd0, dx} * {4'd0, dx})
                                                + 7'({4'd0, dy} * {4'd0, dy}));
            HEUR_OCTAGON: estimate = man - 8'd6 * {5'd0, lo};
            default:      estimate = man;
        endcase
    endfunction
endpackage

FILE: rtl/gasp_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gasp_req_if / gasp_res_if / gasp_cfg_if
// Valid/ready channels for requests, results and register writes.
// ---------------------------------------------------------------------------
interface gasp_req_if;
    logic valid;
    logic ready;
    gasp_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gasp_res_if;
    logic valid;
    logic ready;
    gasp_pkg::t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gasp_cfg_if;
    logic valid;
    logic ready;
    gasp_pkg::t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/grid_astar_path_search_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grid_astar_path_search_top
// A wall edit is captured, then applied. A search repeats an open-set scan (one
// registered read per cell, a drain of the compare, a finish), a decide step
// and the neighbours (a store read and an update each); the path then leaves
// one beat at a time, each after a parent fetch. Items are handled one at a
// time. Synchronous active-low reset clears walls and flags, resets state and config.
// ---------------------------------------------------------------------------
module grid_astar_path_search_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gasp_req_if.sink   req,
    gasp_res_if.source res,
    gasp_cfg_if.sink   cfg
);
    import gasp_pkg::*;

    logic [3:0] r_width, r_height;
    logic r_diag;
    logic [1:0] r_heur;
    t_cmd w_cmd;
    t_sts w_sts;

    assign cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 4'd8;
            r_height <= 4'd8;
            r_diag <= 1'b0;
            r_heur <= HEUR_MANHATTAN;
        end else if (cfg.valid) begin
            if (cfg.data.cfg_index == {1'b0, CFG_WIDTH}) r_width <= cfg.data.cfg_data;
            if (cfg.data.cfg_index == {1'b0, CFG_HEIGHT}) r_height <= cfg.data.cfg_data;
            if (cfg.data.cfg_index == {1'b0, CFG_DIAG}) r_diag <= cfg.data.cfg_data[0];
            if (cfg.data.cfg_index == {1'b0, CFG_HEUR}) r_heur <= cfg.data.cfg_data[1:0];
        end
    end

    gasp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req(req), .res(res),
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    gasp_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_req(req.data),
        .i_width(r_width), .i_height(r_height), .i_diag(r_diag), .i_heur(r_heur),
        .o_sts(w_sts)
    );
endmodule

FILE: rtl/gasp_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gasp_datapath
// Wall map, search stores, open-set scan, neighbour update and path cursor.
// ---------------------------------------------------------------------------
module gasp_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gasp_pkg::t_cmd    i_cmd,
    input  gasp_pkg::t_req    i_req,
    input  logic [3:0]        i_width,
    input  logic [3:0]        i_height,
    input  logic              i_diag,
    input  logic [1:0]        i_heur,
    output gasp_pkg::t_sts    o_sts
);
    import gasp_pkg::*;

    logic [CELL_COUNT-1:0] r_wall, r_open, r_closed;
    t_node r_mem [CELL_COUNT];
    t_node r_rd;
    logic [6:0] r_cnt;
    t_req r_req;
    logic [CW:0] r_scan;
    logic r_cv;
    logic [CW-1:0] r_cq;
    logic [CW-1:0] r_best;
    logic r_has_best;
    logic [10:0] r_best_f;
    logic [6:0] r_best_ord;
    logic [9:0] r_best_g;
    logic [3:0] r_nb;
    logic [2:0] r_px, r_py;

    logic [3:0] w_w, w_h;
    always_comb begin
        w_w = (i_width == 4'd0) ? 4'd1 : (i_width > 4'(GRID_W) ? 4'(GRID_W) : i_width);
        w_h = (i_height == 4'd0) ? 4'd1 : (i_height > 4'(GRID_H) ? 4'(GRID_H) : i_height);
    end

    logic [CW-1:0] w_si, w_gi, w_ci, w_cur;
    logic w_scan_go;
    assign w_si = CW'({r_req.start_y, r_req.start_x});
    assign w_gi = CW'({r_req.goal_y, r_req.goal_x});
    assign w_ci = r_scan[CW-1:0];
    assign w_cur = CW'({r_py, r_px});
    assign w_scan_go = i_cmd.scan_step && !r_scan[CW];

    // The compare runs in the cycle after the read of each cell.
    logic [10:0] w_f;
    logic w_take;
    assign w_f = {1'b0, r_rd.g} + {3'd0, r_rd.h};
    assign w_take = r_cv && r_open[r_cq] && (!r_has_best || w_f < r_best_f ||
                    (w_f == r_best_f && r_rd.ord > r_best_ord));

    // neighbour
    logic [2:0] w_bx, w_by, w_d;
    logic signed [4:0] w_nx, w_ny;
    logic w_in;
    logic [CW-1:0] w_ni;
    logic [10:0] w_cost;
    logic w_upd, w_new, w_better;
    assign w_bx = r_best[2:0];
    assign w_by = r_best[CW-1:3];
    assign w_d = r_nb[2:0];
    assign w_nx = $signed({2'b0, w_bx}) + 5'(step_dx(w_d));
    assign w_ny = $signed({2'b0, w_by}) + 5'(step_dy(w_d));
    assign w_in = (w_nx >= 0) && (w_nx < $signed({1'b0, w_w})) &&
                  (w_ny >= 0) && (w_ny < $signed({1'b0, w_h}));
    assign w_ni = CW'({w_ny[2:0], w_nx[2:0]});
    assign w_cost = {1'b0, r_best_g} + {1'b0, (w_d[2] ? COST_DIAGONAL : COST_STRAIGHT)};
    // The neighbour entry was fetched into r_rd on the cycle before nb_step.
    assign w_upd = i_cmd.nb_step && w_in && !r_wall[w_ni] && !r_closed[w_ni];
    assign w_new = w_upd && !r_open[w_ni];
    assign w_better = w_upd && r_open[w_ni] && (w_cost < {1'b0, r_rd.g});

    // Parent step off the map stops the walk.
    logic signed [4:0] w_ppx, w_ppy;
    logic [2:0] w_pd;
    assign w_pd = r_rd.par;
    assign w_ppx = $signed({2'b0, r_px}) - 5'(step_dx(w_pd));
    assign w_ppy = $signed({2'b0, r_py}) - 5'(step_dy(w_pd));

    logic [CW-1:0] w_rd_addr, w_wr_addr;
    logic w_wr_en;
    t_node w_wr_data;

    always_comb begin
        if (i_cmd.scan_step) w_rd_addr = w_ci;
        else if (i_cmd.nb_read) w_rd_addr = w_ni;
        else w_rd_addr = w_cur;
    end

    always_comb begin
        w_wr_en = 1'b0;
        w_wr_addr = w_ni;
        w_wr_data = r_rd;
        if (i_cmd.seed) begin
            w_wr_en = 1'b1;
            w_wr_addr = w_gi;
            w_wr_data = '{g: 10'd0,
                          h: estimate(r_req.goal_x, r_req.goal_y, r_req.start_x,
                                      r_req.start_y, i_heur),
                          par: 3'd0, ord: r_cnt};
        end else if (w_new) begin
            w_wr_en = 1'b1;
            w_wr_data = '{g: w_cost[9:0],
                          h: estimate(w_nx[2:0], w_ny[2:0], r_req.start_x,
                                      r_req.start_y, i_heur),
                          par: w_d, ord: r_cnt};
        end else if (w_better) begin
            w_wr_en = 1'b1;
            w_wr_data.g = w_cost[9:0];
            w_wr_data.par = w_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[w_wr_addr] <= w_wr_data;
        r_rd <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wall <= '0;
            r_open <= '0;
            r_closed <= '0;
            r_cnt <= '0;
            r_cv <= 1'b0;
        end else begin
            r_cv <= w_scan_go;
            if (i_cmd.wall_clr) r_wall <= '0;
            if (i_cmd.wall_wr)
                r_wall[CW'({r_req.cell_y, r_req.cell_x})] <= (r_req.req_type == REQ_SET_WALL);
            if (i_cmd.clr_flags) begin
                r_open <= '0;
                r_closed <= '0;
                r_cnt <= '0;
            end
            if (i_cmd.seed) begin
                r_open[w_gi] <= 1'b1;
                r_cnt <= r_cnt + 7'd1;
            end
            if (i_cmd.expand) begin
                r_open[r_best] <= 1'b0;
                r_closed[r_best] <= 1'b1;
            end
            if (w_new) begin
                r_open[w_ni] <= 1'b1;
                r_cnt <= r_cnt + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_req;
        if (i_cmd.scan_init) begin
            r_scan <= '0;
            r_has_best <= 1'b0;
        end
        if (w_scan_go) r_scan <= r_scan + 1'b1;
        r_cq <= w_ci;
        if (w_take) begin
            r_has_best <= 1'b1;
            r_best <= r_cq;
            r_best_f <= w_f;
            r_best_ord <= r_rd.ord;
            r_best_g <= r_rd.g;
        end
        if (i_cmd.expand) r_nb <= '0;
        if (i_cmd.nb_step) r_nb <= r_nb + 4'd1;
        if (i_cmd.path_init) begin
            r_px <= r_req.start_x;
            r_py <= r_req.start_y;
        end
        if (i_cmd.path_step) begin
            r_px <= r_px - 3'(step_dx(w_pd));
            r_py <= r_py - 3'(step_dy(w_pd));
        end
    end

    always_comb begin
        o_sts.bad_coord = ({1'b0, r_req.start_x} >= w_w) || ({1'b0, r_req.start_y} >= w_h) ||
                          ({1'b0, r_req.goal_x} >= w_w) || ({1'b0, r_req.goal_y} >= w_h);
        o_sts.scan_done = (r_scan == (CW+1)'(CELL_COUNT)) && !r_cv;
        o_sts.best_none = !r_has_best;
        o_sts.best_is_start = (r_best == w_si);
        o_sts.nb_done = (r_nb == (i_diag ? 4'd8 : 4'd4));
        o_sts.path_at_goal = (r_px == r_req.goal_x) && (r_py == r_req.goal_y);
        o_sts.path_stop = (w_ppx < 0) || (w_ppx >= 5'sd8) || (w_ppy < 0) || (w_ppy >= 5'sd8);
        o_sts.cur_x = r_px;
        o_sts.cur_y = r_py;
    end
endmodule

FILE: rtl/gasp_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gasp_ctrl
// Sequencer for wall edits, search, and path emission.
// ---------------------------------------------------------------------------
module gasp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    gasp_req_if.sink       req,
    gasp_res_if.source     res,
    input  gasp_pkg::t_sts i_sts,
    output gasp_pkg::t_cmd o_cmd
);
    import gasp_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0, S_DISPATCH = 4'd1, S_SEED = 4'd2,
                           S_SCAN = 4'd3, S_DECIDE = 4'd4, S_NB = 4'd5,
                           S_PINIT = 4'd6, S_PATH = 4'd7, S_FAIL = 4'd8,
                           S_OUT = 4'd9, S_NBW = 4'd10, S_PRD = 4'd11;

    logic [3:0] r_state, n_state;
    logic [6:0] r_iter, n_iter;
    logic [6:0] r_n, n_n;
    logic r_valid, n_valid;
    t_res r_res, n_res;
    logic [1:0] r_type;

    assign req.ready = (r_state == S_IDLE);
    assign res.valid = r_valid;
    assign res.data = r_res;

    always_comb begin
        n_state = r_state;
        n_iter = r_iter;
        n_n = r_n;
        n_valid = r_valid;
        n_res = r_res;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (req.valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (r_type)
                    REQ_CLEAR_ALL: begin
                        o_cmd.wall_clr = 1'b1;
                        n_state = S_IDLE;
                    end
                    REQ_SEARCH: begin
                        if (i_sts.bad_coord) n_state = S_FAIL;
                        else begin
                            o_cmd.clr_flags = 1'b1;
                            n_state = S_SEED;
                        end
                    end
                    default: begin
                        o_cmd.wall_wr = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SEED: begin
                o_cmd.seed = 1'b1;
                o_cmd.scan_init = 1'b1;
                n_iter = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_DECIDE;
                else o_cmd.scan_step = 1'b1;
            end
            S_DECIDE: begin
                if (i_sts.best_none || r_iter > 7'(CELL_COUNT)) n_state = S_FAIL;
                else if (i_sts.best_is_start) n_state = S_PINIT;
                else begin
                    o_cmd.expand = 1'b1;
                    n_iter = r_iter + 7'd1;
                    n_state = S_NB;
                end
            end
            S_NB: begin
                if (i_sts.nb_done) begin
                    o_cmd.scan_init = 1'b1;
                    n_state = S_SCAN;
                end else begin
                    o_cmd.nb_read = 1'b1;
                    n_state = S_NBW;
                end
            end
            S_NBW: begin
                o_cmd.nb_step = 1'b1;
                n_state = S_NB;
            end
            S_PINIT: begin
                o_cmd.path_init = 1'b1;
                n_n = '0;
                n_state = S_PRD;
            end
            S_PRD: begin
                // The parent of the cursor cell is fetched here.
                n_state = S_PATH;
            end
            S_PATH: begin
                // Results leave one at a time through the output register.
                if (!r_valid || res.ready) begin
                    n_valid = 1'b1;
                    n_res.path_x = i_sts.cur_x;
                    n_res.path_y = i_sts.cur_y;
                    n_res.found = 1'b1;
                    n_res.last = i_sts.path_at_goal || i_sts.path_stop ||
                                 (r_n == 7'(CELL_COUNT - 1));
                    n_n = r_n + 7'd1;
                    if (n_res.last) n_state = S_OUT;
                    else begin
                        o_cmd.path_step = 1'b1;
                        n_state = S_PRD;
                    end
                end
            end
            S_FAIL: begin
                if (!r_valid || res.ready) begin
                    n_valid = 1'b1;
                    n_res = '{path_x: 3'd0, path_y: 3'd0, found: 1'b0, last: 1'b1};
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (res.ready) begin
                    n_valid = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_valid && res.ready && r_state != S_PATH && r_state != S_FAIL &&
            r_state != S_OUT)
            n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_iter <= '0;
            r_n <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_iter <= n_iter;
            r_n <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (req.valid && req.ready) r_type <= req.data.req_type;
    end
endmodule

FILE: rtl/gasp_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gasp_checker
// Port-level checks on the result channel and request ready.
// ---------------------------------------------------------------------------
module gasp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic req_ready,
    input logic res_valid,
    input logic res_ready,
    input logic res_found,
    input logic res_last
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_ready |=> res_valid) else $error("result dropped");
    a_fail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_found |-> res_last) else $error("failure not last");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !req_ready) else $error("request taken during output");
endmodule

bind grid_astar_path_search_top gasp_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .req_ready(req.ready),
    .res_valid(res.valid), .res_ready(res.ready),
    .res_found(res.data.found), .res_last(res.data.last)
);

FILE: tb/grid_astar_path_search_top_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grid_astar_path_search_top_test
// Drives wall edits and path searches into the grid path search block under
// several grid sizes, move sets and distance estimates. A path model in the
// bench works out each search's cells, and a scoreboard checks every result
// beat against them in order.
// ---------------------------------------------------------------------------
module grid_astar_path_search_top_test;
    import gasp_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    class path_scoreboard;
        t_res pending[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        function void note_request(t_res beats[$]);
            foreach (beats[i]) pending.insert(pending.size(), beats[i]);
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (pending.size() == 0) begin
                $error("result beat with nothing pending: %p", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.path_x !== want.path_x) begin
                $error("path_x expected %0d actual %0d", want.path_x, got.path_x);
                errors++;
            end
            if (got.path_y !== want.path_y) begin
                $error("path_y expected %0d actual %0d", want.path_y, got.path_y);
                errors++;
            end
            if (got.found !== want.found) begin
                $error("found expected %0d actual %0d", want.found, got.found);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last expected %0d actual %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    gasp_req_if req_ch ();
    gasp_res_if res_ch ();
    gasp_cfg_if cfg_ch ();

    grid_astar_path_search_top u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .req    (req_ch.sink),
        .res    (res_ch.source),
        .cfg    (cfg_ch.sink)
    );

    path_scoreboard board;

    // Model state.
    bit        walls[CELL_COUNT];
    bit        is_open[CELL_COUNT];
    bit        is_closed[CELL_COUNT];
    int        g_of[CELL_COUNT];
    int        h_of[CELL_COUNT];
    int        dir_of[CELL_COUNT];
    int        order_of[CELL_COUNT];
    int        order_count;
    logic [3:0] cols_reg, rows_reg;
    logic       diag_reg;
    logic [1:0] heur_reg;
    int        idle_cycles;
    bit        sink_done;

    const int dxs[8] = '{0, 1, 0, -1, -1, 1, -1, 1};
    const int dys[8] = '{1, 0, -1, 0, -1, 1, 1, -1};

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int distance_to(int ax, int ay, int bx, int by);
        int dx, dy, lo, r;
        dx = ax > bx ? ax - bx : bx - ax;
        dy = ay > by ? ay - by : by - ay;
        lo = dx < dy ? dx : dy;
        if (heur_reg == HEUR_EUCLID) begin
            r = 0;
            while ((r + 1) * (r + 1) <= 100 * (dx * dx + dy * dy)) r++;
            return r;
        end
        if (heur_reg == HEUR_OCTAGON) return 10 * (dx + dy) - 6 * lo;
        return 10 * (dx + dy);
    endfunction

    function automatic void push_beat(ref t_res q[$], input int x, input int y,
                                      input bit f, input bit l);
        t_res b;
        b.path_x = 3'(x);
        b.path_y = 3'(y);
        b.found  = f;
        b.last   = l;
        q.insert(q.size(), b);
    endfunction

    // Works out the result beats for one request and updates the wall map.
    function automatic void predict_path(t_req r, ref t_res q[$]);
        int w, h, sx, sy, gx, gy, si, gi, best, bf, f, cx, cy, nx, ny, ni, cost, c, n;
        bit hit;
        q = {};
        if (r.req_type == REQ_CLEAR_ALL) begin
            foreach (walls[i]) walls[i] = 0;
            return;
        end
        if (r.req_type != REQ_SEARCH) begin
            walls[r.cell_y * GRID_W + r.cell_x] = (r.req_type == REQ_SET_WALL);
            return;
        end
        w = cols_reg < 1 ? 1 : (cols_reg > GRID_W ? GRID_W : cols_reg);
        h = rows_reg < 1 ? 1 : (rows_reg > GRID_H ? GRID_H : rows_reg);
        sx = r.start_x; sy = r.start_y; gx = r.goal_x; gy = r.goal_y;
        if (sx >= w || sy >= h || gx >= w || gy >= h) begin
            push_beat(q, 0, 0, 0, 1);
            return;
        end
        foreach (is_open[i]) begin
            is_open[i] = 0;
            is_closed[i] = 0;
        end
        order_count = 0;
        si = sy * GRID_W + sx;
        gi = gy * GRID_W + gx;
        is_open[gi] = 1;
        g_of[gi] = 0;
        h_of[gi] = distance_to(gx, gy, sx, sy);
        dir_of[gi] = 0;
        order_of[gi] = order_count;
        order_count = (order_count + 1) & 127;
        hit = 0;
        for (int it = 0; it <= CELL_COUNT; it++) begin
            best = -1;
            bf = 0;
            for (int k = 0; k < CELL_COUNT; k++) begin
                if (!is_open[k]) continue;
                f = g_of[k] + h_of[k];
                if (best < 0 || f < bf || (f == bf && order_of[k] > order_of[best])) begin
                    best = k;
                    bf = f;
                end
            end
            if (best < 0) break;
            if (best == si) begin
                hit = 1;
                break;
            end
            is_open[best] = 0;
            is_closed[best] = 1;
            cx = best % GRID_W;
            cy = best / GRID_W;
            for (int d = 0; d < (diag_reg ? 8 : 4); d++) begin
                nx = cx + dxs[d];
                ny = cy + dys[d];
                if (nx < 0 || nx >= w || ny < 0 || ny >= h) continue;
                ni = ny * GRID_W + nx;
                if (walls[ni] || is_closed[ni]) continue;
                cost = g_of[best] + (d < 4 ? 10 : 14);
                if (!is_open[ni]) begin
                    is_open[ni] = 1;
                    g_of[ni] = cost & 1023;
                    h_of[ni] = distance_to(nx, ny, sx, sy);
                    dir_of[ni] = d;
                    order_of[ni] = order_count;
                    order_count = (order_count + 1) & 127;
                end else if (cost < g_of[ni]) begin
                    g_of[ni] = cost & 1023;
                    dir_of[ni] = d;
                end
            end
        end
        if (!hit) begin
            push_beat(q, 0, 0, 0, 1);
            return;
        end
        c = si;
        n = 0;
        while (n < CELL_COUNT) begin
            cx = c % GRID_W;
            cy = c / GRID_W;
            push_beat(q, cx, cy, 1, 0);
            n++;
            if (c == gi) break;
            nx = cx - dxs[dir_of[c]];
            ny = cy - dys[dir_of[c]];
            if (nx < 0 || nx >= GRID_W || ny < 0 || ny >= GRID_H) break;
            c = ny * GRID_W + nx;
        end
        q[q.size() - 1].last = 1;
    endfunction

    task automatic send_request(t_req r);
        t_res beats[$];
        repeat ($urandom_range(0, 16)) @(posedge i_clk);
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        req_ch.valid <= 1'b0;
        predict_path(r, beats);
        board.note_request(beats);
        // The block drops ready after taking a beat.
        @(posedge i_clk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [3:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{cfg_index: idx, cfg_data: val};
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        case (idx[1:0])
            CFG_WIDTH:  cols_reg = val;
            CFG_HEIGHT: rows_reg = val;
            CFG_DIAG:   diag_reg = val[0];
            default:    heur_reg = val[1:0];
        endcase
        @(posedge i_clk);
    endtask

    // Waits until all pending beats have come, plus settling time for a
    // trailing wall edit.
    task automatic drain_results();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_mode(int w, int h, bit dg, logic [1:0] hm);
        drain_results();
        write_register({1'b0, CFG_WIDTH}, 4'(w));
        write_register({1'b0, CFG_HEIGHT}, 4'(h));
        write_register({1'b0, CFG_DIAG}, {3'd0, dg});
        write_register({1'b0, CFG_HEUR}, {2'd0, hm});
    endtask

    function automatic t_req make_req(logic [1:0] t, int cx, int cy,
                                      int sx, int sy, int gx, int gy);
        t_req r;
        r.req_type = t;
        r.cell_x = 3'(cx); r.cell_y = 3'(cy);
        r.start_x = 3'(sx); r.start_y = 3'(sy);
        r.goal_x = 3'(gx); r.goal_y = 3'(gy);
        return r;
    endfunction

    function automatic t_req random_req();
        t_req r;
        int p;
        r = 20'($urandom);
        p = $urandom_range(0, 9);
        if (p < 5) r.req_type = REQ_SEARCH;
        else if (p < 7) r.req_type = REQ_SET_WALL;
        else if (p < 9) r.req_type = REQ_CLEAR_WALL;
        else r.req_type = REQ_CLEAR_ALL;
        // Keep most searches inside the active grid.
        if (r.req_type == REQ_SEARCH && $urandom_range(0, 4) != 0) begin
            r.start_x = 3'($urandom_range(0, cols_reg - 1));
            r.goal_x  = 3'($urandom_range(0, cols_reg - 1));
            r.start_y = 3'($urandom_range(0, rows_reg - 1));
            r.goal_y  = 3'($urandom_range(0, rows_reg - 1));
        end
        return r;
    endfunction

    // Result sink with random stalls.
    initial begin
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 3) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            if (res_ch.valid) board.check_result(res_ch.data);
        end
    end

    // Watchdog on cycles with no beat moving.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready) || sink_done) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        board = new();
        sink_done = 0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        i_rst_n <= 1'b0;
        foreach (walls[i]) walls[i] = 0;
        cols_reg = 4'd8; rows_reg = 4'd8; diag_reg = 0; heur_reg = HEUR_MANHATTAN;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset settings.
        send_request(make_req(REQ_SEARCH, 0, 0, 0, 0, 7, 7));
        send_request(make_req(REQ_SEARCH, 0, 0, 7, 7, 0, 0));
        send_request(make_req(REQ_SEARCH, 0, 0, 3, 4, 3, 4));
        send_request(make_req(REQ_SET_WALL, 3, 3, 0, 0, 0, 0));
        send_request(make_req(REQ_SEARCH, 0, 0, 3, 3, 0, 0));
        send_request(make_req(REQ_SEARCH, 0, 0, 3, 3, 3, 3));
        send_request(make_req(REQ_SEARCH, 0, 0, 0, 0, 3, 3));
        send_request(make_req(REQ_CLEAR_WALL, 3, 3, 0, 0, 0, 0));
        // Wall column with a gap, then closed fully.
        for (int y = 0; y < 7; y++) send_request(make_req(REQ_SET_WALL, 4, y, 0, 0, 0, 0));
        send_request(make_req(REQ_SEARCH, 0, 0, 7, 0, 0, 0));
        send_request(make_req(REQ_SET_WALL, 4, 7, 0, 0, 0, 0));
        send_request(make_req(REQ_SEARCH, 0, 0, 7, 0, 0, 0));
        send_request(make_req(REQ_CLEAR_ALL, 7, 7, 7, 7, 7, 7));

        set_mode(1, 1, 1, HEUR_EUCLID);
        send_request(make_req(REQ_SEARCH, 0, 0, 0, 0, 0, 0));
        send_request(make_req(REQ_SEARCH, 0, 0, 1, 0, 0, 0));
        set_mode(15, 0, 0, 2'd3);
        send_request(make_req(REQ_SEARCH, 0, 0, 7, 0, 0, 0));
        set_mode(8, 8, 1, HEUR_OCTAGON);
        send_request(make_req(REQ_SEARCH, 0, 0, 0, 7, 7, 0));
        // Every sender pause above already waits before config; this one
        // holds the sender until every pending beat has arrived.
        drain_results();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_mode(8, 8, 0, HEUR_MANHATTAN);
                1: set_mode(8, 8, 1, HEUR_EUCLID);
                2: set_mode(5, 6, 1, HEUR_OCTAGON);
                3: set_mode(2, 8, 0, HEUR_EUCLID);
                4: set_mode(8, 3, 1, HEUR_MANHATTAN);
                default: set_mode(8, 8, 1, 2'd3);
            endcase
            for (int k = 0; k < 20; k++) send_request(random_req());
        end

        drain_results();
        sink_done = 1;
        repeat (50) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

FILE: sim.f
rtl/gasp_pkg.sv
rtl/gasp_if.sv
rtl/gasp_datapath.sv
rtl/gasp_ctrl.sv
rtl/grid_astar_path_search_top.sv
rtl/gasp_checker.sv
tb/grid_astar_path_search_top_test.sv
